[sv/assert_macros.svh]
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers: implication in the same cycle and in the next cycle.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pidlf_pkg.sv]
// ------------------------------------------------------------------------
// pidlf_pkg
// Widths, register indexes and sequencer states of the PID light
// controller.
// ------------------------------------------------------------------------
package pidlf_pkg;

    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 15;
    localparam int DGAIN_W    = 13;
    localparam int LEVEL_W    = 14;
    localparam int ERR_W      = 15;
    localparam int SUM_W      = 16;
    localparam int DERIV_W    = 16;
    localparam int MA_W       = 21;
    localparam int MB_W       = 17;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = ACC_W - FRAC_W;
    localparam int CORR_W     = 16;
    localparam int DUTY_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [GAIN_W-1:0]  KP_RESET    = 20'd1311;
    localparam logic [GAIN_W-1:0]  KI_RESET    = 20'd16384;
    localparam logic [GAIN_W-1:0]  KD_RESET    = 20'd983;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd10000;
    localparam logic [DGAIN_W-1:0] DGAIN_RESET = 13'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_LIMIT = 3'd3,
        REG_DGAIN = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_SCALE,
        ST_LEVEL,
        ST_MUL_DUTY,
        ST_FINISH
    } state_t;

endpackage

[sv/pidlf_if.sv]
// ------------------------------------------------------------------------
// pidlf_in_if / pidlf_out_if
// Valid/ready channels for sample items and result items.
// ------------------------------------------------------------------------
interface pidlf_in_if;
    logic                           valid;
    logic                           ready;
    logic [pidlf_pkg::LEVEL_W-1:0]  target_level;
    logic [pidlf_pkg::LEVEL_W-1:0]  measured_level;

    modport source (output valid, output target_level, output measured_level, input ready);
    modport sink   (input valid, input target_level, input measured_level, output ready);
endinterface

interface pidlf_out_if;
    logic                               valid;
    logic                               ready;
    logic [pidlf_pkg::DUTY_W-1:0]       duty_count;
    logic signed [pidlf_pkg::CORR_W-1:0] correction;

    modport source (output valid, output duty_count, output correction, input ready);
    modport sink   (input valid, input duty_count, input correction, output ready);
endinterface

[sv/pidlf_mul.sv]
// ------------------------------------------------------------------------
// pidlf_mul
// Shared signed multiplier with a registered product.
// ------------------------------------------------------------------------
module pidlf_mul
(
    input  logic                                 clk,
    input  logic signed [pidlf_pkg::MA_W-1:0]    a_op,
    input  logic signed [pidlf_pkg::MB_W-1:0]    b_op,
    output logic signed [pidlf_pkg::PROD_W-1:0]  prod
);

    logic signed [pidlf_pkg::PROD_W-1:0] prod_reg;
    logic signed [pidlf_pkg::PROD_W-1:0] prod_next;

    assign prod_next = pidlf_pkg::PROD_W'(a_op) * pidlf_pkg::PROD_W'(b_op);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[sv/pid_light_feedforward_controller_unit.sv]
// ------------------------------------------------------------------------
// pid_light_feedforward_controller_unit
// PID light controller: clamped integral, derivative, Q16 correction and
// duty drive, all products on one shared multiplier.
// ------------------------------------------------------------------------
//  channel    dir   handshake      payload
//  in_item    in    valid/ready    target_level, measured_level
//  out_item   out   valid/ready    duty_count, correction
//  cfg        in    cfg_we         cfg_index, cfg_data
//
//  An item steps from acceptance through PREP, MUL_P, MUL_I, MUL_D, ACC,
//  SCALE, LEVEL and MUL_DUTY to FINISH; in_item.ready is high again from
//  the edge that loads the result, so a new item is taken only after the
//  last one is through. The sequencer walks four products (kp, ki, kd, duty
//  gain) through the single multiplier, with one accumulate, one scaling
//  and one level step between kd and duty gain. A full output register
//  holds the last step while stalled. Reset restores the gains and clears the integral and previous error.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_light_feedforward_controller_unit
#(
    parameter int DUTY_FULL_SCALE = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    pidlf_in_if.sink                            in_item,
    pidlf_out_if.source                         out_item,
    input  logic                                cfg_we,
    input  logic [pidlf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidlf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ERR_W   = pidlf_pkg::ERR_W;
    localparam int SUM_W   = pidlf_pkg::SUM_W;
    localparam int DERIV_W = pidlf_pkg::DERIV_W;
    localparam int MA_W    = pidlf_pkg::MA_W;
    localparam int MB_W    = pidlf_pkg::MB_W;
    localparam int PROD_W  = pidlf_pkg::PROD_W;
    localparam int ACC_W   = pidlf_pkg::ACC_W;
    localparam int FRAC_W  = pidlf_pkg::FRAC_W;
    localparam int QUO_W   = pidlf_pkg::QUO_W;
    localparam int CORR_W  = pidlf_pkg::CORR_W;
    localparam int DUTY_W  = pidlf_pkg::DUTY_W;
    localparam int LEVEL_W = pidlf_pkg::LEVEL_W;

    localparam logic signed [PROD_W-1:0] FULL_S   = PROD_W'(DUTY_FULL_SCALE);
    localparam logic signed [QUO_W-1:0]  CORR_MAX = QUO_W'(32767);
    localparam logic signed [QUO_W-1:0]  CORR_MIN = -QUO_W'(32768);
    localparam logic signed [ACC_W-1:0]  ROUND_IN = ACC_W'((1 << FRAC_W) - 1);

    // configuration
    logic [pidlf_pkg::GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic [pidlf_pkg::LIMIT_W-1:0] limit_reg;
    logic [pidlf_pkg::DGAIN_W-1:0] dgain_reg;

    // state and datapath
    pidlf_pkg::state_t             state_reg, state_next;
    logic signed [SUM_W-1:0]       error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]       prior_error_reg, prior_error_next;
    logic signed [ERR_W-1:0]       err_reg, err_next;
    logic [LEVEL_W-1:0]            target_reg, target_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [DERIV_W-1:0]     deriv_reg, deriv_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [CORR_W-1:0]      corr_reg, corr_next;
    logic signed [MB_W-1:0]        level_reg, level_next;
    logic                          out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]             duty_out_reg, duty_out_next;
    logic signed [CORR_W-1:0]      corr_out_reg, corr_out_next;

    logic signed [MA_W-1:0]        mul_a;
    logic signed [MB_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]      prod;

    logic signed [ERR_W-1:0]       in_err;
    logic signed [SUM_W:0]         sum_wide;
    logic signed [SUM_W:0]         lim_pos;
    logic signed [ACC_W-1:0]       acc_adj;
    logic signed [QUO_W-1:0]       quo;
    logic signed [PROD_W-1:0]      drive;
    logic                          in_fire;

    pidlf_mul u_mul
    (
        .clk  (clk),
        .a_op (mul_a),
        .b_op (mul_b),
        .prod (prod)
    );

    assign in_item.ready = (state_reg == pidlf_pkg::ST_IDLE);
    assign in_fire       = in_item.valid && in_item.ready;
    assign in_err        = $signed({1'b0, in_item.target_level})
                         - $signed({1'b0, in_item.measured_level});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= pidlf_pkg::KP_RESET;
            ki_reg    <= pidlf_pkg::KI_RESET;
            kd_reg    <= pidlf_pkg::KD_RESET;
            limit_reg <= pidlf_pkg::LIMIT_RESET;
            dgain_reg <= pidlf_pkg::DGAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (pidlf_pkg::cfg_reg_t'(cfg_index))
                pidlf_pkg::REG_KP:    kp_reg    <= cfg_data;
                pidlf_pkg::REG_KI:    ki_reg    <= cfg_data;
                pidlf_pkg::REG_KD:    kd_reg    <= cfg_data;
                pidlf_pkg::REG_LIMIT: limit_reg <= cfg_data[pidlf_pkg::LIMIT_W-1:0];
                pidlf_pkg::REG_DGAIN: dgain_reg <= cfg_data[pidlf_pkg::DGAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pidlf_pkg::ST_IDLE;
            error_sum_reg   <= '0;
            prior_error_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            error_sum_reg   <= error_sum_next;
            prior_error_reg <= prior_error_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        target_reg   <= target_next;
        sum_reg      <= sum_next;
        deriv_reg    <= deriv_next;
        acc_reg      <= acc_next;
        corr_reg     <= corr_next;
        level_reg    <= level_next;
        duty_out_reg <= duty_out_next;
        corr_out_reg <= corr_out_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        error_sum_next   = error_sum_reg;
        prior_error_next = prior_error_reg;
        err_next         = err_reg;
        target_next      = target_reg;
        sum_next         = sum_reg;
        deriv_next       = deriv_reg;
        acc_next         = acc_reg;
        corr_next        = corr_reg;
        level_next       = level_reg;
        out_valid_next   = out_valid_reg && !out_item.ready;
        duty_out_next    = duty_out_reg;
        corr_out_next    = corr_out_reg;
        mul_a            = '0;
        mul_b            = '0;

        sum_wide = SUM_W'(error_sum_reg) + (SUM_W + 1)'(err_reg);
        lim_pos  = $signed({2'b00, limit_reg});
        acc_adj  = acc_reg + (acc_reg[ACC_W-1] ? ROUND_IN : '0);
        quo      = acc_adj[ACC_W-1:FRAC_W];
        drive    = prod;

        case (state_reg)
            pidlf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    target_next = in_item.target_level;
                    err_next    = in_err;
                    state_next  = pidlf_pkg::ST_PREP;
                end
            end
            pidlf_pkg::ST_PREP:
            begin
                if (sum_wide > lim_pos)
                    sum_next = lim_pos[SUM_W-1:0];
                else if (sum_wide < -lim_pos)
                    sum_next = SUM_W'(-lim_pos);
                else
                    sum_next = sum_wide[SUM_W-1:0];
                error_sum_next   = sum_next;
                deriv_next       = DERIV_W'(err_reg) - DERIV_W'(prior_error_reg);
                prior_error_next = err_reg;
                state_next       = pidlf_pkg::ST_MUL_P;
            end
            pidlf_pkg::ST_MUL_P:
            begin
                mul_a      = $signed({1'b0, kp_reg});
                mul_b      = MB_W'(err_reg);
                state_next = pidlf_pkg::ST_MUL_I;
            end
            pidlf_pkg::ST_MUL_I:
            begin
                mul_a      = $signed({1'b0, ki_reg});
                mul_b      = MB_W'(sum_reg);
                acc_next   = ACC_W'(prod);
                state_next = pidlf_pkg::ST_MUL_D;
            end
            pidlf_pkg::ST_MUL_D:
            begin
                mul_a      = $signed({1'b0, kd_reg});
                mul_b      = MB_W'(deriv_reg);
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = pidlf_pkg::ST_ACC;
            end
            pidlf_pkg::ST_ACC:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = pidlf_pkg::ST_SCALE;
            end
            pidlf_pkg::ST_SCALE:
            begin
                if (quo > CORR_MAX)
                    corr_next = CORR_MAX[CORR_W-1:0];
                else if (quo < CORR_MIN)
                    corr_next = CORR_MIN[CORR_W-1:0];
                else
                    corr_next = quo[CORR_W-1:0];
                state_next = pidlf_pkg::ST_LEVEL;
            end
            pidlf_pkg::ST_LEVEL:
            begin
                level_next = $signed({3'b000, target_reg}) + MB_W'(corr_reg);
                state_next = pidlf_pkg::ST_MUL_DUTY;
            end
            pidlf_pkg::ST_MUL_DUTY:
            begin
                mul_a      = MA_W'($signed({1'b0, dgain_reg}));
                mul_b      = level_reg;
                state_next = pidlf_pkg::ST_FINISH;
            end
            pidlf_pkg::ST_FINISH:
            begin
                // keep the duty product alive while the output is stalled
                mul_a = MA_W'($signed({1'b0, dgain_reg}));
                mul_b = level_reg;
                if (prod < 0)
                    drive = '0;
                else if (prod > FULL_S)
                    drive = FULL_S;
                if (!out_valid_reg || out_item.ready)
                begin
                    out_valid_next = 1'b1;
                    duty_out_next  = drive[DUTY_W-1:0];
                    corr_out_next  = corr_reg;
                    state_next     = pidlf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidlf_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_item.valid      = out_valid_reg;
    assign out_item.duty_count = duty_out_reg;
    assign out_item.correction = corr_out_reg;

    `ASSERT_NXT(a_accept_starts, clk, rst_n, in_fire, state_reg == pidlf_pkg::ST_PREP, "accepted item did not start the sequence")
    `ASSERT_NXT(a_sum_clamped, clk, rst_n, state_reg == pidlf_pkg::ST_PREP, (error_sum_reg <= $signed({1'b0, limit_reg})) && (error_sum_reg >= -$signed({1'b0, limit_reg})), "integral outside its limit")
    `ASSERT_NXT(a_finish_loads, clk, rst_n, (state_reg == pidlf_pkg::ST_FINISH) && !out_valid_reg, out_valid_reg && (state_reg == pidlf_pkg::ST_IDLE), "result not loaded into free output register")
    `ASSERT_IMP(a_busy_not_ready, clk, rst_n, (state_reg != pidlf_pkg::ST_IDLE), !in_fire, "item accepted while sequence busy")

endmodule
